/* design/tcw_pkg.sv */
// Shared constants and types of the text console writer.
`default_nettype none

package tcw_pkg;

    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = COLS * ROWS;

    localparam int COL_W  = $clog2(COLS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int IDX_W  = $clog2(CELLS + 1);
    localparam int CHAR_W = 8;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

    typedef enum logic [1:0] {
        K_PUT   = 2'd0,
        K_SET   = 2'd1,
        K_CLEAR = 2'd2,
        K_READ  = 2'd3
    } t_kind;

endpackage

`default_nettype wire

/* design/text_console_writer_core.sv */
// Text console writer: character store, cursor, scroll and clear sequencer.
//
// The block keeps a COLS by ROWS character store in one synchronous memory
// and a cursor. Items arrive on the s_axis channel: tuser carries the kind
// (put character, set cursor, clear screen, read cell) and tdata carries the
// character and the target column and row. Each item yields one result item
// on m_axis with the cursor column, row and linear index after the item, the
// character read for a read-cell item and a flag that tells whether the item
// scrolled the screen.
// A put character or set cursor item passes from the idle state to the result
// state, a read cell item through a memory read state in between. A clear walks
// the store one cell a cycle. A scroll copies one cell a cycle through the
// read-then-write pipeline and then blanks the bottom row. One item is worked
// on at a time; s_axis_tready is high only while the sequencer is idle.
// After reset the cursor is at 0,0 and the store is blanked by a fill pass over
// all CELLS cells during which no item is accepted.
// The result sits in an output register, so a new item is accepted while the
// receiver stalls; the following result waits until that register frees.
`default_nettype none

module text_console_writer_core
    import tcw_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // char_code [7:0], target_col [14:8], target_row [19:15], zero fill above
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    // kind [1:0]
    input  wire logic [1:0]          s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // cursor_col [6:0], cursor_row [11:7], cursor_index [22:12],
    // cell_code [30:23], scrolled [31]
    output logic [M_DATA_W-1:0]      m_axis_tdata
);

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_BLANK,
        S_FIN
    } t_state;

    localparam logic [IDX_W-1:0] LAST_CELL   = IDX_W'(CELLS - 1);
    localparam logic [IDX_W-1:0] BOTTOM_BASE = IDX_W'(CELLS - COLS);
    localparam logic [IDX_W-1:0] LAST_COPY   = IDX_W'(CELLS - COLS - 1);
    localparam logic [IDX_W-1:0] ROW_STRIDE  = IDX_W'(COLS);
    localparam logic [ROW_W-1:0] LAST_ROW    = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_END     = COL_W'(COLS);

    function automatic logic [IDX_W-1:0] cell_index(input logic [COL_W-1:0] col,
                                                     input logic [ROW_W-1:0] row);
        cell_index = IDX_W'(row) * ROW_STRIDE + IDX_W'(col);
    endfunction

    logic [CHAR_W-1:0] mem [CELLS];

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_addr, n_addr;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic               r_emit, n_emit;
    logic               r_scr, n_scr;
    logic               r_put, n_put;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic [CHAR_W-1:0]  r_cell, n_cell;
    logic               r_rdok, n_rdok;
    logic               r_out_valid, n_out_valid;
    logic [M_DATA_W-1:0] r_out_data, n_out_data;

    // Delayed write stage: copies take their data from the read register.
    logic               r_wv;
    logic [IDX_W-1:0]   r_wa;
    logic [CHAR_W-1:0]  r_wd;
    logic               r_wcopy;
    logic               push_v;
    logic [IDX_W-1:0]   push_a;
    logic [CHAR_W-1:0]  push_d;
    logic               push_copy;

    logic [IDX_W-1:0]   rd_addr;
    logic [CHAR_W-1:0]  r_rdata;

    t_kind              in_kind;
    logic [CHAR_W-1:0]  in_char;
    logic [COL_W-1:0]   in_col;
    logic [ROW_W-1:0]   in_row;
    logic               in_range;
    logic               out_free;

    assign in_kind  = t_kind'(s_axis_tuser);
    assign in_char  = s_axis_tdata[CHAR_W-1:0];
    assign in_col   = s_axis_tdata[CHAR_W +: COL_W];
    assign in_row   = s_axis_tdata[CHAR_W + COL_W +: ROW_W];
    assign in_range = (in_col < COL_END) && (32'(in_row) < ROWS);
    assign out_free = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_col       = r_col;
        n_row       = r_row;
        n_emit      = r_emit;
        n_scr       = r_scr;
        n_put       = r_put;
        n_char      = r_char;
        n_cell      = r_cell;
        n_rdok      = r_rdok;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        push_v      = 1'b0;
        push_a      = r_addr;
        push_d      = BLANK_CHAR;
        push_copy   = 1'b0;
        rd_addr     = '0;

        unique case (r_state)
            S_FILL: begin
                push_v = 1'b1;
                if (r_addr == LAST_CELL) begin
                    n_addr  = '0;
                    n_state = r_emit ? S_FIN : S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_scr  = 1'b0;
                    n_cell = '0;
                    n_put  = 1'b0;
                    n_emit = 1'b1;
                    n_state = S_FIN;
                    unique case (in_kind)
                        K_PUT: begin
                            if (in_char == NEWLINE_CHAR) begin
                                n_col = '0;
                                if (r_row == LAST_ROW) begin
                                    n_scr   = 1'b1;
                                    n_addr  = '0;
                                    n_state = S_SCROLL;
                                end else begin
                                    n_row = r_row + 1'b1;
                                end
                            end else if (r_col >= COL_END) begin
                                // Pending wrap: the character lands at column 0 of the next row.
                                n_col = COL_W'(1);
                                if (r_row == LAST_ROW) begin
                                    n_scr   = 1'b1;
                                    n_put   = 1'b1;
                                    n_char  = in_char;
                                    n_addr  = '0;
                                    n_state = S_SCROLL;
                                end else begin
                                    n_row  = r_row + 1'b1;
                                    push_v = 1'b1;
                                    push_a = cell_index('0, r_row + 1'b1);
                                    push_d = in_char;
                                end
                            end else begin
                                push_v = 1'b1;
                                push_a = cell_index(r_col, r_row);
                                push_d = in_char;
                                n_col  = r_col + 1'b1;
                            end
                        end
                        K_SET: begin
                            n_col = (in_col < COL_END) ? in_col : COL_W'(COLS - 1);
                            n_row = (32'(in_row) < ROWS) ? in_row : LAST_ROW;
                        end
                        K_CLEAR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_addr  = '0;
                            n_state = S_FILL;
                        end
                        K_READ: begin
                            rd_addr = in_range ? cell_index(in_col, in_row) : '0;
                            n_rdok  = in_range;
                            n_state = S_READ;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                n_cell  = r_rdok ? r_rdata : '0;
                n_state = S_FIN;
            end
            S_SCROLL: begin
                rd_addr   = r_addr + ROW_STRIDE;
                push_v    = 1'b1;
                push_copy = 1'b1;
                n_addr    = r_addr + 1'b1;
                if (r_addr == LAST_COPY) begin
                    n_state = S_BLANK;
                end
            end
            S_BLANK: begin
                push_v = 1'b1;
                if (r_put && (r_addr == BOTTOM_BASE)) begin
                    push_d = r_char;
                end
                if (r_addr == LAST_CELL) begin
                    n_addr  = '0;
                    n_state = S_FIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_scr, r_cell, cell_index(r_col, r_row), r_row, r_col};
                    n_emit      = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_addr      <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
            r_wv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_col       <= n_col;
            r_row       <= n_row;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
            r_wv        <= push_v;
        end
        r_scr      <= n_scr;
        r_put      <= n_put;
        r_char     <= n_char;
        r_cell     <= n_cell;
        r_rdok     <= n_rdok;
        r_out_data <= n_out_data;
        r_wa       <= push_a;
        r_wd       <= push_d;
        r_wcopy    <= push_copy;
    end

    always_ff @(posedge i_clk) begin
        if (r_wv) begin
            mem[r_wa] <= r_wcopy ? r_rdata : r_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[rd_addr];
    end

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wv |-> (r_wa <= LAST_CELL))
        else $error("store write beyond last cell");

    a_cursor_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= LAST_ROW) && (r_col <= COL_END))
        else $error("cursor out of bounds");

    a_scroll_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[M_DATA_W-1]) |->
            (r_out_data[COL_W +: ROW_W] == LAST_ROW))
        else $error("scrolled result not on last row");

    a_scroll_then_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL && n_state != S_SCROLL) |=> (r_state == S_BLANK))
        else $error("scroll pass did not hand over to bottom row blanking");

endmodule

`default_nettype wire

/* tb/text_console_writer_checker.sv */
// Channel monitor with a console predictor and a field-by-field result check.
`timescale 1ns / 100ps

module text_console_writer_checker
    import tcw_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    input  wire logic                i_s_tready,
    // char_code [7:0], target_col [14:8], target_row [19:15], zero fill above
    input  wire logic [S_DATA_W-1:0] i_s_tdata,
    // kind [1:0]
    input  wire logic [1:0]          i_s_tuser,
    input  wire logic                i_m_tvalid,
    input  wire logic                i_m_tready,
    // cursor_col [6:0], cursor_row [11:7], cursor_index [22:12],
    // cell_code [30:23], scrolled [31]
    input  wire logic [M_DATA_W-1:0] i_m_tdata,
    output int                       o_error_count,
    output int                       o_pending,
    output int                       o_result_count,
    output int                       o_scroll_count
);

    // Member order follows the result item from its top bit down.
    typedef struct packed {
        logic              scrolled;
        logic [CHAR_W-1:0] cell_code;
        logic [IDX_W-1:0]  index;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_console_status;

    logic [CHAR_W-1:0] screen [CELLS];
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    t_console_status   status_queue [$];

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++) screen[i] = BLANK_CHAR;
    endfunction

    // Moves to column 0 of the next row; on the last row the screen scrolls up.
    function automatic logic next_line();
        cursor_col = '0;
        if (cursor_row + 1 >= ROWS) begin
            for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = BLANK_CHAR;
            return 1'b1;
        end
        cursor_row = cursor_row + 1'b1;
        return 1'b0;
    endfunction

    function automatic t_console_status console_apply(t_kind kind, logic [7:0] code,
                                                      logic [6:0] tcol, logic [4:0] trow);
        t_console_status res;
        res = '0;
        case (kind)
            K_PUT: begin
                if (code == NEWLINE_CHAR) begin
                    res.scrolled = next_line();
                end else begin
                    // A column resting at COLS means a wrap is still owed.
                    if (cursor_col >= COLS) res.scrolled = next_line();
                    screen[int'(cursor_row) * COLS + int'(cursor_col)] = code;
                    cursor_col = cursor_col + 1'b1;
                end
            end
            K_SET: begin
                cursor_col = (tcol < COLS) ? COL_W'(tcol) : COL_W'(COLS - 1);
                cursor_row = (trow < ROWS) ? ROW_W'(trow) : ROW_W'(ROWS - 1);
            end
            K_CLEAR: begin
                blank_screen();
                cursor_col = '0;
                cursor_row = '0;
            end
            K_READ: begin
                if (tcol < COLS && trow < ROWS)
                    res.cell_code = screen[int'(trow) * COLS + int'(tcol)];
            end
        endcase
        res.col   = cursor_col;
        res.row   = cursor_row;
        res.index = IDX_W'(int'(cursor_row) * COLS + int'(cursor_col));
        return res;
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_console_status want;
        t_console_status got;
        if (!i_rst_n) begin
            blank_screen();
            cursor_col = '0;
            cursor_row = '0;
            status_queue.delete();
        end else begin
            // The result side goes first: an item accepted at this edge cannot
            // have produced a result at the same edge.
            if (i_m_tvalid && i_m_tready) begin
                got = t_console_status'(i_m_tdata);
                o_result_count++;
                if (status_queue.size() == 0) begin
                    $display("%0t: result %h arrived with no item outstanding",
                             $time, i_m_tdata);
                    o_error_count++;
                end else begin
                    want = status_queue.pop_front();
                    compare_field("cursor_col", want.col, got.col);
                    compare_field("cursor_row", want.row, got.row);
                    compare_field("cursor_index", want.index, got.index);
                    compare_field("cell_code", want.cell_code, got.cell_code);
                    compare_field("scrolled", want.scrolled, got.scrolled);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                want = console_apply(t_kind'(i_s_tuser), i_s_tdata[7:0],
                                     i_s_tdata[14:8], i_s_tdata[19:15]);
                if (want.scrolled) o_scroll_count++;
                status_queue.push_back(want);
            end
        end
        o_pending = status_queue.size();
    end

endmodule

/* tb/text_console_writer_core_test.sv */
// Top of the console writer test: clock, reset, item stimulus, sink stalls and verdict.
`timescale 1ns / 100ps

module text_console_writer_core_test;
    import tcw_pkg::*;

    localparam int RANDOM_ITEMS = 800;
    localparam int DIRECTED_ITEMS = 25;

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [1:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    int  error_count;
    int  pending;
    int  result_count;
    int  scroll_count;
    int  items_sent;
    int  clears_sent;
    bit  no_gaps;
    int  sink_hold;
    int  sink_cycle;

    text_console_writer_core u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    text_console_writer_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .o_error_count  (error_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_scroll_count (scroll_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #100_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
    end

    // Sink: random stalls, mostly short, with a recurring window in which no new stall starts.
    always @(posedge clk) begin
        int r;
        sink_cycle++;
        r = $urandom_range(0, 99);
        if (sink_hold > 0) begin
            sink_hold--;
            m_tready <= 1'b0;
        end else if (sink_cycle[9:8] == 2'b00 || r < 60) begin
            m_tready <= 1'b1;
        end else begin
            sink_hold = (r < 92) ? $urandom_range(0, 2) : $urandom_range(10, 50);
            m_tready <= 1'b0;
        end
    end

    // Presents one item, holds it until accepted, then maybe leaves a gap.
    task automatic send_item(t_kind kind, logic [7:0] code, logic [6:0] tcol,
                             logic [4:0] trow);
        int r;
        int n;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, trow, tcol, code};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
        if (kind == K_CLEAR) clears_sent++;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return;
        n = (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_char(int newline_pct);
        if ($urandom_range(0, 99) < newline_pct) return NEWLINE_CHAR;
        return 8'($urandom_range(0, 255));
    endfunction

    // Puts a run of characters; the unused target fields carry random bits.
    task automatic put_run(int count, int newline_pct);
        for (int i = 0; i < count; i++)
            send_item(K_PUT, pick_char(newline_pct), 7'($urandom), 5'($urandom));
    endtask

    task automatic read_span(int col, int row, int count);
        for (int i = 0; i < count; i++)
            send_item(K_READ, 8'($urandom), 7'((col + i > 127) ? 127 : col + i), 5'(row));
    endtask

    // Lowers valid and waits, within a bound, until no result is outstanding.
    task automatic wait_for_results();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0 && guard < 50000) begin
            @(negedge clk);
            guard++;
        end
        @(posedge clk);
    endtask

    initial begin
        int pick;
        int col;
        int row;
        int n;
        bit paused;
        paused = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: character extremes, pending wrap, scroll, saturation, clear.
        no_gaps = 1'b0;
        send_item(K_READ, 8'h00, 7'd0, 5'd0);
        send_item(K_PUT, 8'h41, 7'd0, 5'd0);
        send_item(K_PUT, 8'hFF, 7'd0, 5'd0);
        send_item(K_PUT, 8'h00, 7'd0, 5'd0);
        read_span(0, 0, 3);
        send_item(K_PUT, NEWLINE_CHAR, 7'd0, 5'd0);
        send_item(K_SET, 8'h00, 7'd79, 5'd24);
        send_item(K_PUT, 8'h5A, 7'd0, 5'd0);
        send_item(K_PUT, 8'h61, 7'd0, 5'd0);
        send_item(K_READ, 8'hFF, 7'd79, 5'd23);
        send_item(K_READ, 8'h00, 7'd0, 5'd24);
        send_item(K_SET, 8'hFF, 7'd127, 5'd31);
        send_item(K_PUT, NEWLINE_CHAR, 7'd127, 5'd31);
        send_item(K_READ, 8'h00, 7'd127, 5'd31);
        send_item(K_READ, 8'h00, 7'd80, 5'd0);
        send_item(K_READ, 8'h00, 7'd0, 5'd25);
        send_item(K_SET, 8'h00, 7'd79, 5'd0);
        send_item(K_PUT, 8'h78, 7'd0, 5'd0);
        send_item(K_PUT, NEWLINE_CHAR, 7'd0, 5'd0);
        send_item(K_READ, 8'h00, 7'd79, 5'd0);
        send_item(K_CLEAR, 8'hFF, 7'd127, 5'd31);
        send_item(K_READ, 8'h00, 7'd79, 5'd0);
        send_item(K_READ, 8'h00, 7'd0, 5'd23);

        // Random: mostly positioned text runs with readback, some noise.
        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if (!paused && items_sent > DIRECTED_ITEMS + RANDOM_ITEMS / 2) begin
                wait_for_results();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                if ($urandom_range(0, 9) == 0) begin
                    col = $urandom_range(0, 127);
                    row = $urandom_range(0, 31);
                end else begin
                    col = $urandom_range(0, COLS - 1);
                    row = $urandom_range(0, ROWS - 2);
                end
                send_item(K_SET, 8'($urandom), 7'(col), 5'(row));
                n = $urandom_range(1, 12);
                put_run(n, 8);
                read_span(col, row, $urandom_range(1, n));
            end else if (pick < 65) begin
                // Runs off the end of a row to exercise the pending wrap.
                col = $urandom_range(COLS - 8, COLS - 1);
                row = $urandom_range(0, ROWS - 2);
                send_item(K_SET, 8'($urandom), 7'(col), 5'(row));
                put_run($urandom_range(4, 14), 3);
                read_span(col, row, $urandom_range(1, 3));
                read_span(0, row + 1, $urandom_range(0, 3));
            end else if (pick < 72) begin
                // Text on the bottom rows can scroll the screen.
                col = $urandom_range(0, COLS - 1);
                row = $urandom_range(ROWS - 3, ROWS - 1);
                send_item(K_SET, 8'($urandom), 7'(col), 5'(row));
                put_run($urandom_range(3, 10), 20);
                read_span(0, ROWS - 2, $urandom_range(0, 3));
            end else if (pick < 74) begin
                send_item(K_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
            end else begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 19) == 0)
                        pick = $urandom_range(0, 3);
                    else
                        pick = ($urandom_range(0, 2) == 2) ? int'(K_READ)
                                                           : $urandom_range(0, 1);
                    send_item(t_kind'(pick), 8'($urandom), 7'($urandom), 5'($urandom));
                end
            end
        end

        wait_for_results();
        repeat (20) @(posedge clk);
        $display("Sent %0d items (%0d clears), checked %0d results, %0d of them scrolled.",
                 items_sent, clears_sent, result_count, scroll_count);
        if (pending != 0)
            $display("%0d results never arrived", pending);
        if (error_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/tcw_pkg.sv
design/text_console_writer_core.sv
tb/text_console_writer_checker.sv
tb/text_console_writer_core_test.sv
